>>> rtl/b64d_pkg.sv
// ============================================================================
// b64d_pkg - base64 stream decoder shared definitions
// Payload structs, result status codes, character classes and queue sizing.
// ============================================================================
package b64d_pkg;

    // Depth of the queue between the front and back halves
    localparam int unsigned QUEUE_DEPTH = 2;

    // ASCII code of the padding character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_PADDING = 2'd2,
        ST_LENGTH  = 2'd3
    } status_t;

    // Character classes found by the front half
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_PAD  = 2'd1,
        KIND_BAD  = 2'd2
    } char_kind_t;

    // Input request
    typedef struct packed {
        logic [7:0] in_char;
        logic       last_char;
    } in_t;

    // Result request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
        status_t    status;
    } out_t;

    // Classified character as held in the queue
    typedef struct packed {
        char_kind_t kind;
        logic [5:0] sextet;
        logic       last;
    } sym_t;

endpackage

>>> rtl/b64d_front.sv
// ============================================================================
// b64d_front - input acceptance and character classification
// Maps each accepted character to its sextet and class, pushes it to the queue.
// ============================================================================
module b64d_front (
    input  logic            s_valid,
    output logic            s_ready,
    input  b64d_pkg::in_t   s_data,
    input  logic            q_full,
    output logic            q_push,
    output b64d_pkg::sym_t  q_sym
);

    logic [7:0] ch;

    assign ch      = s_data.in_char;
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'; NUL falls out as invalid
    always_comb begin
        q_sym.last   = s_data.last_char;
        q_sym.kind   = b64d_pkg::KIND_DATA;
        q_sym.sextet = 6'd0;
        if (ch inside {[8'h41:8'h5A]}) begin
            q_sym.sextet = 6'(ch - 8'h41);
        end else if (ch inside {[8'h61:8'h7A]}) begin
            q_sym.sextet = 6'(ch - 8'h61 + 8'd26);
        end else if (ch inside {[8'h30:8'h39]}) begin
            q_sym.sextet = 6'(ch - 8'h30 + 8'd52);
        end else if (ch == 8'h2B) begin
            q_sym.sextet = 6'd62;
        end else if (ch == 8'h2F) begin
            q_sym.sextet = 6'd63;
        end else if (ch == b64d_pkg::PAD_CHAR) begin
            q_sym.kind = b64d_pkg::KIND_PAD;
        end else begin
            q_sym.kind = b64d_pkg::KIND_BAD;
        end
    end

endmodule

>>> rtl/b64d_fifo.sv
// ============================================================================
// b64d_fifo - short queue between front and back halves
// Flip-flop storage, combinational read of the head entry.
// ============================================================================
module b64d_fifo #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full && !pop |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/b64d_back.sv
// ============================================================================
// b64d_back - group tracking, byte splice and result register
// Executes classified characters, latches the first error, drives results.
// ============================================================================
module b64d_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  b64d_pkg::sym_t  q_sym,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output b64d_pkg::out_t  m_data
);

    logic [1:0]        pos_reg, pos_next;
    logic [5:0]        prev_reg, prev_next;
    logic              pad_reg, pad_next;
    b64d_pkg::status_t stat_reg, stat_next;
    logic              out_valid_reg;
    b64d_pkg::out_t    out_reg;

    b64d_pkg::status_t err;
    logic              have_byte;
    logic [7:0]        byte_val;
    logic              emit;
    b64d_pkg::out_t    result;

    // Result register frees up when empty or being taken
    assign q_pop   = !q_empty && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        pos_next  = pos_reg;
        prev_next = prev_reg;
        pad_next  = pad_reg;
        err       = stat_reg;
        have_byte = 1'b0;
        byte_val  = 8'd0;
        if (stat_reg == b64d_pkg::ST_OK) begin
            case (q_sym.kind)
                b64d_pkg::KIND_DATA: begin
                    if (pad_reg) begin
                        err = b64d_pkg::ST_PADDING;
                    end else begin
                        case (pos_reg)
                            2'd1: begin
                                byte_val  = {prev_reg, q_sym.sextet[5:4]};
                                have_byte = 1'b1;
                            end
                            2'd2: begin
                                byte_val  = {prev_reg[3:0], q_sym.sextet[5:2]};
                                have_byte = 1'b1;
                            end
                            2'd3: begin
                                byte_val  = {prev_reg[1:0], q_sym.sextet};
                                have_byte = 1'b1;
                            end
                            default: begin
                                have_byte = 1'b0;
                            end
                        endcase
                        prev_next = q_sym.sextet;
                    end
                end
                b64d_pkg::KIND_PAD: begin
                    // '=' only at slot 3, or at slot 2 then slot 3
                    if (pos_reg == 2'd3 || (pos_reg == 2'd2 && !pad_reg)) begin
                        pad_next = 1'b1;
                    end else begin
                        err = b64d_pkg::ST_PADDING;
                    end
                end
                default: begin
                    err = b64d_pkg::ST_INVALID;
                end
            endcase
            if (err != b64d_pkg::ST_OK) begin
                have_byte = 1'b0;
                byte_val  = 8'd0;
            end else begin
                pos_next = pos_reg + 2'd1;
            end
        end
        stat_next = err;

        result.data_byte   = byte_val;
        result.byte_valid  = have_byte;
        result.message_end = q_sym.last;
        result.status      = b64d_pkg::ST_OK;
        emit               = have_byte || q_sym.last;
        if (q_sym.last) begin
            result.status = (err == b64d_pkg::ST_OK && pos_reg != 2'd3) ?
                            b64d_pkg::ST_LENGTH : err;
            pos_next  = 2'd0;
            prev_next = 6'd0;
            pad_next  = 1'b0;
            stat_next = b64d_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 2'd0;
            prev_reg      <= 6'd0;
            pad_reg       <= 1'b0;
            stat_reg      <= b64d_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                pos_reg       <= pos_next;
                prev_reg      <= prev_next;
                pad_reg       <= pad_next;
                stat_reg      <= stat_next;
                out_valid_reg <= emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= result;
        end
    end

    a_status_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.message_end |-> m_data.status == b64d_pkg::ST_OK)
        else $error("status reported before message end");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_valid |-> m_data.data_byte == 8'd0)
        else $error("stray data with no byte");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_sym.last |=> pos_reg == 2'd0 && !pad_reg &&
                                stat_reg == b64d_pkg::ST_OK)
        else $error("state not cleared after message end");

endmodule

>>> rtl/base64_stream_decoder_top.sv
// ============================================================================
// base64_stream_decoder_top - streaming base64 decoder, one character a cycle unless m_ready stalls
// Standard alphabet with '=' padding; one decoded byte or end marker out.
// ============================================================================
// Usage:
//   s_* channel: one ASCII character per request, last_char marks the final
//   character of a message. m_* channel: zero or one result per character;
//   a byte at group slots 1 to 3, and always one result (message_end set,
//   with status) for the final character.
//   Path: an accepted character is classified by the front into the queue,
//   then executed by the back half into the result register, which drives
//   m_valid.
//   Throughput: one character per cycle sustained while the receiver takes
//   each result, set by the back half, which executes one queued character per cycle.
//   Receiver stall: the result register holds; the back half stops popping,
//   the queue (QUEUE_DEPTH entries) absorbs the next characters, then s_ready
//   drops until the receiver takes the result.
//   Errors: the first error of a message is latched; later characters give
//   no result until the final one, which reports that status with no byte.
//   Reset: aresetn is synchronous, active low; queue empty, no result
//   pending, group position, previous sextet and error latch cleared.
// ============================================================================
module base64_stream_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  b64d_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output b64d_pkg::out_t  m_data
);

    localparam int unsigned SYM_W = $bits(b64d_pkg::sym_t);

    // Queue handshake between the halves
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    b64d_pkg::sym_t q_wr_sym;
    b64d_pkg::sym_t q_rd_sym;

    // Front: accept and classify
    b64d_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_sym   (q_wr_sym)
    );

    // Decoupling queue
    b64d_fifo #(
        .WIDTH (SYM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_sym),
        .pop     (q_pop),
        .rd_data (q_rd_sym),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back: decode and deliver
    b64d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_sym   (q_rd_sym),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
